### src/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and constants for the stable priority queue update core
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int QUEUE_DEPTH = 32;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [3:0] SEV_MIN = 4'd1;
	localparam logic [3:0] SEV_MAX = 4'd10;

	typedef enum logic [1:0] {
		FN_PUSH   = 2'd0,
		FN_POP    = 2'd1,
		FN_PEEK   = 2'd2,
		FN_UPDATE = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_FULL      = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_BAD_SEV   = 3'd4
	} status_t;

	// operation token travelling down the cell chain
	typedef struct packed {
		logic             vld;
		func_t            func;
		logic [7:0]       id;
		logic [3:0]       sev;
		logic [15:0]      arr;
		logic             sev_ok;
		logic             hit;
		logic             best_vld;
		logic [7:0]       best_id;
		logic [3:0]       best_sev;
		logic [15:0]      best_arr;
		logic [IDX_W-1:0] best_idx;
	} tok_t;

	// slot invalidate broadcast after a pop
	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] idx;
	} clr_t;

endpackage

### src/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// one queue slot: holds an entry, acts on the passing token and forwards it
// ----------------------------------------------------------------------------
module spq_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [spq_pkg::IDX_W-1:0] my_idx,
	input  spq_pkg::tok_t            tok_in,
	input  spq_pkg::clr_t            clr,
	output spq_pkg::tok_t            tok_out
);
	import spq_pkg::*;

	logic        valid_q;
	logic [7:0]  id_q;
	logic [3:0]  sev_q;
	logic [15:0] arr_q;

	tok_t tok_nxt;
	logic take;
	logic upd;
	logic above;

	always_comb begin
		tok_nxt = tok_in;
		take    = 1'b0;
		upd     = 1'b0;
		above   = (sev_q > tok_in.best_sev) ||
		          ((sev_q == tok_in.best_sev) && (arr_q < tok_in.best_arr));
		if (tok_in.vld) begin
			case (tok_in.func)
				FN_PUSH: begin
					if (!tok_in.hit && !valid_q) begin
						take        = 1'b1;
						tok_nxt.hit = 1'b1;
					end
				end
				FN_POP, FN_PEEK: begin
					if (valid_q && (!tok_in.best_vld || above)) begin
						tok_nxt.best_vld = 1'b1;
						tok_nxt.best_id  = id_q;
						tok_nxt.best_sev = sev_q;
						tok_nxt.best_arr = arr_q;
						tok_nxt.best_idx = my_idx;
					end
				end
				FN_UPDATE: begin
					if (tok_in.sev_ok && valid_q && (id_q == tok_in.id)) begin
						upd         = 1'b1;
						tok_nxt.hit = 1'b1;
					end
				end
				default: begin
					tok_nxt = tok_in;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_out <= '0;
		end else begin
			tok_out <= tok_nxt;
			if (take) begin
				valid_q <= 1'b1;
			end else if (clr.vld && (clr.idx == my_idx)) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			id_q  <= tok_in.id;
			sev_q <= tok_in.sev;
			arr_q <= tok_in.arr;
		end else if (upd) begin
			sev_q <= tok_in.sev;
		end
	end

endmodule

### src/stable_priority_queue_update_core.sv
// ----------------------------------------------------------------------------
// stable_priority_queue_update_core
// priority queue built as a chain of slot cells, one operation token at a time
// flow: each token is registered in every cell of the chain, one cell per cycle,
//   then in a holding register and then in the result beat registers; a new
//   operation is taken only once the last result has left the holding register
// reset: all slots empty, occupancy zero, no result pending
// ----------------------------------------------------------------------------
module stable_priority_queue_update_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [7:0]  patient_id,
	input  logic [3:0]  severity,
	input  logic [15:0] arrival_time,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [7:0]  top_id,
	output logic [3:0]  top_severity,
	output logic [15:0] top_arrival,
	output logic [5:0]  occupancy
);
	import spq_pkg::*;

	logic busy_q;
	logic in_acc;
	logic xfer;

	tok_t tok_entry;
	tok_t chain [QUEUE_DEPTH];
	tok_t done_q;
	clr_t clr;

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_nxt;
	logic [CNT_W+5:0] cnt_ext;

	status_t     st_nxt;
	logic        show_top;
	logic        out_valid_q;
	status_t     status_q;
	logic [7:0]  top_id_q;
	logic [3:0]  top_sev_q;
	logic [15:0] top_arr_q;
	logic [5:0]  occ_q;

	assign in_ready = !busy_q;
	assign in_acc   = in_valid && in_ready;

	always_comb begin
		tok_entry        = '0;
		tok_entry.vld    = in_acc;
		tok_entry.func   = func_t'(func);
		tok_entry.id     = patient_id;
		tok_entry.sev    = severity;
		tok_entry.arr    = arrival_time;
		tok_entry.sev_ok = (severity >= SEV_MIN) && (severity <= SEV_MAX);
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		spq_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.my_idx  (IDX_W'(i)),
			.tok_in  ((i == 0) ? tok_entry : chain[(i == 0) ? 0 : i - 1]),
			.clr     (clr),
			.tok_out (chain[i])
		);
	end

	assign xfer = done_q.vld && (!out_valid_q || out_ready);

	always_comb begin
		clr.vld  = xfer && (done_q.func == FN_POP) && done_q.best_vld;
		clr.idx  = done_q.best_idx;
		show_top = 1'b0;
		cnt_nxt  = cnt_q;
		st_nxt   = ST_OK;
		case (done_q.func)
			FN_PUSH: begin
				if (done_q.hit) begin
					cnt_nxt = cnt_q + CNT_W'(1);
				end else begin
					st_nxt = ST_FULL;
				end
			end
			FN_POP, FN_PEEK: begin
				if (done_q.best_vld) begin
					show_top = 1'b1;
					if (done_q.func == FN_POP) begin
						cnt_nxt = cnt_q - CNT_W'(1);
					end
				end else begin
					st_nxt = ST_EMPTY;
				end
			end
			FN_UPDATE: begin
				if (!done_q.sev_ok) begin
					st_nxt = ST_BAD_SEV;
				end else if (!done_q.hit) begin
					st_nxt = ST_NOT_FOUND;
				end
			end
			default: begin
				st_nxt = ST_OK;
			end
		endcase
		cnt_ext = {6'd0, cnt_nxt};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			done_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				busy_q <= 1'b1;
			end else if (xfer) begin
				busy_q <= 1'b0;
			end
			if (chain[QUEUE_DEPTH-1].vld) begin
				done_q <= chain[QUEUE_DEPTH-1];
			end else if (xfer) begin
				done_q.vld <= 1'b0;
			end
			if (xfer) begin
				cnt_q       <= cnt_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (xfer) begin
			status_q  <= st_nxt;
			top_id_q  <= show_top ? done_q.best_id : 8'd0;
			top_sev_q <= show_top ? done_q.best_sev : 4'd0;
			top_arr_q <= show_top ? done_q.best_arr : 16'd0;
			occ_q     <= cnt_ext[5:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign top_id       = top_id_q;
	assign top_severity = top_sev_q;
	assign top_arrival  = top_arr_q;
	assign occupancy    = occ_q;

endmodule
